/* src/stsu_pkg.sv */
// Shared types and constants for the software timer scheduler.
// Holds the request/result words and the controller-datapath command and status structs.
// No dependencies.
package stsu_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        REQ_PERIODIC = 2'd0,
        REQ_ONESHOT  = 2'd1,
        REQ_CANCEL   = 2'd2,
        REQ_PROCESS  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_STARTED = 3'd0,
        ST_FULL    = 3'd1,
        ST_BADINT  = 3'd2,
        ST_FIRED   = 3'd3,
        ST_ACK     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        EM_BADINT,
        EM_FULL,
        EM_START,
        EM_CANCEL,
        EM_FIRE_ONE,
        EM_FIRE_PER,
        EM_WAIT
    } t_emit;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] interval_ms;
        logic [3:0]  timer_id;
    } t_req_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_id;
        logic [15:0] missed_periods;
        logic [31:0] delay_ms;
        logic        last;
    } t_res_word;

    typedef struct packed {
        logic  latch;
        logic  scan_clr;
        logic  scan_run;
        logic  alloc;
        logic  cancel;
        logic  free_best;
        logic  adv_add;
        logic  adv_sub;
        logic  div_step;
        logic  mul;
        logic  commit;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic bad_interval;
        logic full;
        logic scan_done;
        logic found;
        logic best_cancel;
        logic best_periodic;
        logic div_done;
    } t_stat;

endpackage

/* src/stsu_ram.sv */
// Generic simple dual-port RAM with registered read.
// One write port, one read port. No dependencies.
module stsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/stsu_datapath.sv */
// Datapath of the timer scheduler: slot flags, slot RAM, scan pipeline,
// period catch-up divider and multiplier, result register.
// Depends on stsu_pkg and stsu_ram.
module stsu_datapath import stsu_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req_word i_req,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic      o_strobe,
    output t_res_word o_res
);

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] SCAN_END = CW'(TIMER_SLOTS);

    // request latch
    t_req_word r_in;

    // slot flags and insertion counter
    logic [TIMER_SLOTS-1:0] r_valid, r_periodic, r_cancel;
    logic [31:0]            r_cnt;

    // free slot search
    logic          w_free_found;
    logic [IW-1:0] w_free_idx;

    // cancel target
    logic [31:0]   w_tid32;
    logic          w_tid_ok;
    logic [IW-1:0] w_tid_idx;

    // slot RAM: {seq, interval, start}
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [95:0]   w_wdata;
    logic          w_re;
    logic [95:0]   w_rdata;

    // scan pipeline
    logic [CW-1:0] r_addr;
    logic          r_rd_v;
    logic [IW-1:0] r_rd_idx;
    logic          r_a_v;
    logic          r_a_live;
    logic [IW-1:0] r_a_idx;
    logic [31:0]   r_a_diff, r_a_ivl, r_a_age, r_a_start;
    logic          w_due;
    logic [31:0]   w_over, w_tt;
    logic          w_better;

    // best candidate and minimum delay
    logic          r_found;
    logic [IW-1:0] r_best_idx;
    logic [31:0]   r_best_over, r_best_age, r_best_start, r_best_ivl;
    logic [31:0]   r_min;

    // period catch-up
    logic [31:0] r_st1, r_q, r_prod;
    logic [32:0] r_rem;
    logic [5:0]  r_div_cnt;
    logic [32:0] w_rem_sh;
    logic        w_sub_ok;
    logic [31:0] w_prod;
    logic [31:0] w_new_st;

    // result
    logic        r_strobe;
    t_res_word   r_res;
    t_res_word   n_res;
    logic [31:0] w_free32, w_best32;

    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    assign w_tid32   = 32'(r_in.timer_id);
    assign w_tid_ok  = w_tid32 < 32'(TIMER_SLOTS);
    assign w_tid_idx = w_tid32[IW-1:0];

    assign w_new_st = r_st1 + r_prod;
    assign w_we     = i_cmd.alloc || i_cmd.commit;
    assign w_waddr  = i_cmd.alloc ? w_free_idx : r_best_idx;
    assign w_wdata  = i_cmd.alloc ? {r_cnt, r_in.interval_ms, r_in.now_ms}
                                  : {r_cnt, r_best_ivl, w_new_st};
    assign w_re     = i_cmd.scan_run && (r_addr != SCAN_END);

    stsu_ram #(
        .WIDTH (96),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_due  = r_a_diff >= r_a_ivl;
    assign w_over = r_a_diff - r_a_ivl;
    assign w_tt   = w_due ? 32'd0 : (r_a_ivl - r_a_diff);
    assign w_better = r_a_live && w_due &&
                      (!r_found || (w_over > r_best_over) ||
                       ((w_over == r_best_over) && (r_a_age < r_best_age)));

    assign w_rem_sh = {r_rem[31:0], r_q[31]};
    assign w_sub_ok = w_rem_sh >= {1'b0, r_best_ivl};
    assign w_prod   = r_q * r_best_ivl;

    assign w_free32 = 32'(w_free_idx);
    assign w_best32 = 32'(r_best_idx);

    always_comb begin
        n_res = '0;
        case (i_cmd.emit_kind)
            EM_BADINT: begin
                n_res.status = ST_BADINT;
                n_res.last   = 1'b1;
            end
            EM_FULL: begin
                n_res.status = ST_FULL;
                n_res.last   = 1'b1;
            end
            EM_START: begin
                n_res.status  = ST_STARTED;
                n_res.slot_id = w_free32[3:0];
                n_res.last    = 1'b1;
            end
            EM_CANCEL: begin
                n_res.status  = ST_ACK;
                n_res.slot_id = r_in.timer_id;
                n_res.last    = 1'b1;
            end
            EM_FIRE_ONE: begin
                n_res.status  = ST_FIRED;
                n_res.slot_id = w_best32[3:0];
            end
            EM_FIRE_PER: begin
                n_res.status  = ST_FIRED;
                n_res.slot_id = w_best32[3:0];
                n_res.missed_periods = (r_q[31:16] != 16'd0) ? 16'hFFFF : r_q[15:0];
            end
            default: begin
                n_res.status   = ST_ACK;
                n_res.delay_ms = r_min;
                n_res.last     = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_periodic <= '0;
            r_cancel   <= '0;
            r_cnt      <= '0;
            r_addr     <= '0;
            r_rd_v     <= 1'b0;
            r_a_v      <= 1'b0;
            r_found    <= 1'b0;
            r_div_cnt  <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.alloc) begin
                r_valid[w_free_idx]    <= 1'b1;
                r_periodic[w_free_idx] <= (r_in.req_type == REQ_PERIODIC);
                r_cancel[w_free_idx]   <= 1'b0;
            end
            if (i_cmd.cancel && w_tid_ok && r_valid[w_tid_idx]) begin
                r_cancel[w_tid_idx] <= 1'b1;
            end
            if (i_cmd.free_best) begin
                r_valid[r_best_idx] <= 1'b0;
            end
            if (i_cmd.alloc || i_cmd.commit) begin
                r_cnt <= r_cnt + 32'd1;
            end
            if (i_cmd.scan_clr) begin
                r_addr  <= '0;
                r_rd_v  <= 1'b0;
                r_a_v   <= 1'b0;
                r_found <= 1'b0;
            end else begin
                r_rd_v <= w_re;
                r_a_v  <= r_rd_v;
                if (w_re) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (r_a_v && w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.adv_sub) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 6'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_req;
        end
        r_rd_idx <= r_addr[IW-1:0];
        if (r_rd_v) begin
            r_a_live  <= r_valid[r_rd_idx];
            r_a_idx   <= r_rd_idx;
            r_a_start <= w_rdata[31:0];
            r_a_ivl   <= w_rdata[63:32];
            r_a_diff  <= r_in.now_ms - w_rdata[31:0];
            r_a_age   <= r_cnt - w_rdata[95:64];
        end
        if (i_cmd.scan_clr) begin
            r_min <= '1;
        end else if (r_a_v) begin
            if (w_better) begin
                r_best_idx   <= r_a_idx;
                r_best_over  <= w_over;
                r_best_age   <= r_a_age;
                r_best_start <= r_a_start;
                r_best_ivl   <= r_a_ivl;
            end
            if (r_a_live && (w_tt < r_min)) begin
                r_min <= w_tt;
            end
        end
        if (i_cmd.adv_add) begin
            r_st1 <= r_best_start + r_best_ivl;
        end
        // restoring divide of the overrun by the period
        if (i_cmd.adv_sub) begin
            r_q   <= r_in.now_ms - r_st1;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_sub_ok ? (w_rem_sh - {1'b0, r_best_ivl}) : w_rem_sh;
            r_q   <= {r_q[30:0], w_sub_ok};
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.emit) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        o_stat.req           = t_req'(r_in.req_type);
        o_stat.bad_interval  = (r_in.req_type == REQ_PERIODIC) && (r_in.interval_ms == 32'd0);
        o_stat.full          = !w_free_found;
        o_stat.scan_done     = (r_addr == SCAN_END) && !r_rd_v && !r_a_v;
        o_stat.found         = r_found;
        o_stat.best_cancel   = r_cancel[r_best_idx];
        o_stat.best_periodic = r_periodic[r_best_idx];
        o_stat.div_done      = r_div_cnt == 6'd32;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* src/stsu_ctrl.sv */
// Controller state machine of the timer scheduler.
// Sequences requests, scan passes and periodic catch-up. Depends on stsu_pkg.
module stsu_ctrl import stsu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REQ,
        S_SCAN,
        S_PICK,
        S_SUB,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_REQ;
                end
            end
            S_REQ: begin
                case (i_stat.req)
                    REQ_CANCEL: begin
                        o_cmd.cancel    = 1'b1;
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = EM_CANCEL;
                        n_state         = S_IDLE;
                    end
                    REQ_PROCESS: begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default: begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.bad_interval) begin
                            o_cmd.emit_kind = EM_BADINT;
                        end else if (i_stat.full) begin
                            o_cmd.emit_kind = EM_FULL;
                        end else begin
                            o_cmd.emit_kind = EM_START;
                            o_cmd.alloc     = 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!i_stat.found) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_WAIT;
                    n_state         = S_IDLE;
                end else if (i_stat.best_cancel) begin
                    // drop silently and rescan
                    o_cmd.free_best = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_state         = S_SCAN;
                end else if (!i_stat.best_periodic) begin
                    o_cmd.free_best = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EM_FIRE_ONE;
                    o_cmd.scan_clr  = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.adv_add = 1'b1;
                    n_state       = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.adv_sub = 1'b1;
                n_state       = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_COMMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit    = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_kind = EM_FIRE_PER;
                o_cmd.scan_clr  = 1'b1;
                n_state         = S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

/* src/software_timer_scheduler_unit.sv */
// Timer scheduler top level: start, cancel and process requests over TIMER_SLOTS slots.
// Start and cancel: one registered result once the request is decoded; the next request may follow.
// Process: each scan pass reads the slot RAM one slot per cycle through the RAM read port;
// a periodic fire adds a bit-serial divide before the slot is rewritten.
// Results are registered and shown for one cycle on o_strobe; the receiver cannot stall.
// Synchronous active-low reset empties all slots and clears the insertion counter.
module software_timer_scheduler_unit import stsu_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_req_word i_req,
    output logic      o_strobe,
    output t_res_word o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;

    stsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    stsu_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule

/* tb/software_timer_scheduler_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the software timer scheduler: directed table then random requests,
// every result checked against an in-bench timer queue predictor.
// Depends on stsu_pkg and software_timer_scheduler_unit.
module software_timer_scheduler_unit_tb;
    import stsu_pkg::*;

    localparam int SLOTS = TIMER_SLOTS_DEF;
    localparam int N_RANDOM = 131;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_req_word i_req;
    logic      o_strobe;
    t_res_word o_res;

    software_timer_scheduler_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // predictor state
    bit          tq_valid [SLOTS];
    bit          tq_periodic [SLOTS];
    bit          tq_cancelled [SLOTS];
    logic [31:0] tq_start [SLOTS];
    logic [31:0] tq_interval [SLOTS];
    logic [31:0] tq_seq [SLOTS];
    logic [31:0] tq_counter;

    t_res_word expected_words[$];
    int        fail_count;
    logic [31:0] clock_ms;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic t_res_word make_word(t_status st, logic [3:0] id, logic [15:0] miss,
                                            logic [31:0] dly, logic lst);
        t_res_word w;
        w.status = st; w.slot_id = id; w.missed_periods = miss; w.delay_ms = dly;
        w.last = lst;
        return w;
    endfunction

    function automatic logic [31:0] time_to_target(int s, logic [31:0] now);
        logic [31:0] diff;
        diff = now - tq_start[s];
        return (diff >= tq_interval[s]) ? 32'd0 : tq_interval[s] - diff;
    endfunction

    task automatic predict_request(input t_req_word rq);
        int          best;
        logic [31:0] best_over, best_age, diff, over, age, st, dly, miss, p;
        bit          done;
        if (rq.req_type == REQ_PERIODIC || rq.req_type == REQ_ONESHOT) begin
            if (rq.req_type == REQ_PERIODIC && rq.interval_ms == 0) begin
                expected_words.push_back(make_word(ST_BADINT, 0, 0, 0, 1));
                return;
            end
            for (int s = 0; s < SLOTS; s++) begin
                if (!tq_valid[s]) begin
                    tq_valid[s] = 1; tq_periodic[s] = (rq.req_type == REQ_PERIODIC);
                    tq_cancelled[s] = 0; tq_start[s] = rq.now_ms;
                    tq_interval[s] = rq.interval_ms; tq_seq[s] = tq_counter;
                    tq_counter++;
                    expected_words.push_back(make_word(ST_STARTED, s, 0, 0, 1));
                    return;
                end
            end
            expected_words.push_back(make_word(ST_FULL, 0, 0, 0, 1));
            return;
        end
        if (rq.req_type == REQ_CANCEL) begin
            if (tq_valid[rq.timer_id]) tq_cancelled[rq.timer_id] = 1;
            expected_words.push_back(make_word(ST_ACK, rq.timer_id, 0, 0, 1));
            return;
        end
        done = 0;
        while (!done) begin
            best = -1; best_over = 0; best_age = 0;
            for (int s = 0; s < SLOTS; s++) begin
                if (tq_valid[s] && time_to_target(s, rq.now_ms) == 0) begin
                    diff = rq.now_ms - tq_start[s];
                    over = diff - tq_interval[s];
                    age = tq_counter - tq_seq[s];
                    if (best < 0 || over > best_over || (over == best_over && age < best_age))
                    begin
                        best = s; best_over = over; best_age = age;
                    end
                end
            end
            if (best < 0) begin
                done = 1;
            end else if (tq_cancelled[best]) begin
                tq_valid[best] = 0;
            end else if (!tq_periodic[best]) begin
                tq_valid[best] = 0;
                expected_words.push_back(make_word(ST_FIRED, best, 0, 0, 0));
            end else begin
                p = tq_interval[best];
                st = tq_start[best] + p;
                miss = (rq.now_ms - st) / p;
                st = st + miss * p;
                tq_start[best] = st;
                tq_seq[best] = tq_counter;
                tq_counter++;
                expected_words.push_back(make_word(ST_FIRED, best,
                    (miss > 65535) ? 16'hFFFF : miss[15:0], 0, 0));
            end
        end
        dly = '1;
        for (int s = 0; s < SLOTS; s++)
            if (tq_valid[s] && time_to_target(s, rq.now_ms) < dly)
                dly = time_to_target(s, rq.now_ms);
        expected_words.push_back(make_word(ST_ACK, 0, 0, dly, 1));
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res_word exp_w;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %p", o_res));
            end else begin
                exp_w = expected_words[0];
                expected_words.delete(0);
                if (o_res.status !== exp_w.status)
                    report_mismatch($sformatf("status %0d exp %0d", o_res.status, exp_w.status));
                if (o_res.slot_id !== exp_w.slot_id)
                    report_mismatch($sformatf("slot_id %0d exp %0d", o_res.slot_id,
                                              exp_w.slot_id));
                if (o_res.missed_periods !== exp_w.missed_periods)
                    report_mismatch($sformatf("missed %0d exp %0d", o_res.missed_periods,
                                              exp_w.missed_periods));
                if (o_res.delay_ms !== exp_w.delay_ms)
                    report_mismatch($sformatf("delay %0h exp %0h", o_res.delay_ms,
                                              exp_w.delay_ms));
                if (o_res.last !== exp_w.last)
                    report_mismatch($sformatf("last %0b exp %0b", o_res.last, exp_w.last));
            end
        end
    end

    int burst_left;

    // drive one request: random gaps between bursts, then hold until accepted
    task automatic send_request(input t_req_word rq, input bit has_fixed,
                                input t_res_word fixed_word);
        bit accepted;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        i_req <= rq;
        accepted = 1'b0;
        // busy at the falling edge decides acceptance at the next rising edge
        while (!accepted) begin
            @(negedge i_clk);
            accepted = !busy;
            @(posedge i_clk);
        end
        // accepted at this edge: predict now
        if (has_fixed) begin
            predict_request(rq);
            if (expected_words[$] != fixed_word)
                report_mismatch($sformatf("table row disagrees with predictor %p", rq));
        end else begin
            predict_request(rq);
        end
    endtask

    function automatic t_req_word mk(t_req r, logic [31:0] now, logic [31:0] ivl,
                                     logic [3:0] id);
        t_req_word w;
        w.req_type = r; w.now_ms = now; w.interval_ms = ivl; w.timer_id = id;
        return w;
    endfunction

    typedef struct {
        t_req_word rq;
        bit        fixed;
        t_res_word res;
    } t_row;

    t_row plan[$];

    task automatic add_row(t_req_word rq, bit fx, t_res_word w);
        t_row r;
        r.rq = rq; r.fixed = fx; r.res = w;
        plan.push_back(r);
    endtask

    initial begin
        t_req_word rq;
        int        kind;
        logic [31:0] ivl;
        t_res_word none;
        none = '0;
        fail_count = 0;
        burst_left = 0;
        tq_counter = 0;
        clock_ms = 0;
        for (int s = 0; s < SLOTS; s++) begin
            tq_valid[s] = 0; tq_periodic[s] = 0; tq_cancelled[s] = 0;
        end
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(mk(REQ_PROCESS, 0, 0, 0), 1, make_word(ST_ACK, 0, 0, '1, 1));
        add_row(mk(REQ_PERIODIC, 5, 0, 0), 1, make_word(ST_BADINT, 0, 0, 0, 1));
        add_row(mk(REQ_CANCEL, 0, 0, 4'hF), 1, make_word(ST_ACK, 4'hF, 0, 0, 1));
        add_row(mk(REQ_ONESHOT, 100, 0, 0), 1, make_word(ST_STARTED, 0, 0, 0, 1));
        add_row(mk(REQ_PERIODIC, 100, 10, 0), 1, make_word(ST_STARTED, 1, 0, 0, 1));
        add_row(mk(REQ_PERIODIC, 100, 10, 0), 1, make_word(ST_STARTED, 2, 0, 0, 1));
        add_row(mk(REQ_PERIODIC, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0), 0, none);
        add_row(mk(REQ_ONESHOT, 95, 7, 0), 0, none);
        add_row(mk(REQ_CANCEL, 0, 0, 2), 1, make_word(ST_ACK, 2, 0, 0, 1));
        add_row(mk(REQ_PROCESS, 135, 0, 0), 0, none);
        add_row(mk(REQ_PERIODIC, 0, 1, 0), 0, none);
        add_row(mk(REQ_PROCESS, 32'h0100_0000, 0, 0), 0, none);
        add_row(mk(REQ_PROCESS, 32'h0100_0005, 0, 0), 0, none);
        for (int k = 0; k < 13; k++)
            add_row(mk(REQ_ONESHOT, 32'h0100_0005, 32'h8000_0000 + k, 0), 0, none);
        add_row(mk(REQ_ONESHOT, 0, 1, 0), 1, make_word(ST_FULL, 0, 0, 0, 1));
        add_row(mk(REQ_PROCESS, 32'hFFFF_FFFF, 0, 0), 0, none);
        add_row(mk(REQ_PROCESS, 32'h0100_0006, 0, 0), 0, none);
        foreach (plan[i]) send_request(plan[i].rq, plan[i].fixed, plan[i].res);

        // random part: mostly starts with small intervals and advancing time
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            clock_ms += $urandom_range(0, 40);
            if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
            ivl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
            if (kind < 35)
                rq = mk(REQ_PERIODIC, clock_ms, ivl, $urandom);
            else if (kind < 55)
                rq = mk(REQ_ONESHOT, clock_ms, ivl, $urandom);
            else if (kind < 70)
                rq = mk(REQ_CANCEL, $urandom, $urandom, $urandom);
            else
                rq = mk(REQ_PROCESS, clock_ms, $urandom, $urandom);
            send_request(rq, 0, none);
        end
        start <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
